[design/json_string_unescape_top_macros.svh]
// assertion macros shared by the json string unescape design
`ifndef JSON_STRING_UNESCAPE_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// plain property checked on clk_i, quiet during reset
`define JSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// overlapping implication checked on clk_i, quiet during reset
`define JSU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked on clk_i, quiet during reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define JSU_ASSERT(label, prop, msg)
`define JSU_ASSERT_IMPL(label, ante, cons, msg)
`define JSU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/jsu_pkg.sv]
// types, codes and helper functions of the json string unescape block
package jsu_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned AccumW = 16;

  localparam logic [PhaseW-1:0] PH_SKIP = 4'd0;
  localparam logic [PhaseW-1:0] PH_STR  = 4'd1;
  localparam logic [PhaseW-1:0] PH_ESC  = 4'd2;
  localparam logic [PhaseW-1:0] PH_HEX0 = 4'd3;
  localparam logic [PhaseW-1:0] PH_HEX1 = 4'd4;
  localparam logic [PhaseW-1:0] PH_HEX2 = 4'd5;
  localparam logic [PhaseW-1:0] PH_HEX3 = 4'd6;
  localparam logic [PhaseW-1:0] PH_DONE = 4'd7;
  localparam logic [PhaseW-1:0] PH_ERR  = 4'd8;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_FF = 8'h0c;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_ASCII_MAX = 8'h7f;

  // one input request
  typedef struct packed {
    logic [7:0] text_char;
    logic       first_char;
    logic       last_char;
  } jsu_item_t;

  // one result request
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
  } jsu_result_t;

  // decoder state
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AccumW-1:0] accum;
  } jsu_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // bit 4 set when c is not a hex digit, else the digit value
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[design/json_string_unescape_top.sv]
// top level of the json string unescape block: input register, decoder, result register
// a text byte is held in the input register, decoded, and its result held in the result register
// throughput: one text byte per cycle, one result per byte, while the result receiver does not stall;
//   the decoder state loop closes through the phase and hex accumulator registers
// reset: rst_ni low clears both stage valids and puts the decoder in whitespace skip
`include "json_string_unescape_top_macros.svh"

module json_string_unescape_top import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // text byte channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_char_i,
  input  logic       first_char_i,
  input  logic       last_char_i,
  // decoded result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] status_o
);

  // input register stage
  logic        s1_valid_q;
  jsu_item_t   s1_item_q;
  // result register stage
  logic        s2_valid_q;
  jsu_result_t s2_result_q;
  // decoder state, updated once per request that moves into the result stage
  jsu_state_t  state_q;
  jsu_state_t  state_d;
  jsu_result_t result_d;

  logic s2_ready;
  logic s1_ready;
  logic s1_adv;
  logic in_take;

  // result stage frees up when empty or when its request leaves this cycle
  assign s2_ready = !s2_valid_q || !out_stall_i;
  // input stage frees up when empty or when its request moves on
  assign s1_adv   = s1_valid_q && s2_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_take  = in_valid_i && s1_ready;

  jsu_decode u_decode (
    .state_i  (state_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // valids and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      state_q.phase <= PH_SKIP;
      state_q.accum <= '0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s1_adv) state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.text_char  <= text_char_i;
      s1_item_q.first_char <= first_char_i;
      s1_item_q.last_char  <= last_char_i;
    end
    if (s1_adv) s2_result_q <= result_d;
  end

  assign out_valid_o  = s2_valid_q;
  assign out_byte_o   = s2_result_q.out_byte;
  assign byte_valid_o = s2_result_q.byte_valid;
  assign status_o     = s2_result_q.status;

  // a decoded byte is only ever reported while the string is still open
  `JSU_ASSERT_IMPL(a_byte_only_busy, s2_valid_q && s2_result_q.byte_valid,
                   s2_result_q.status == ST_BUSY, "decoded byte with final status")
  // an error result carries no byte
  `JSU_ASSERT_IMPL(a_err_no_byte, s2_valid_q && s2_result_q.status == ST_ERR,
                   !s2_result_q.byte_valid && s2_result_q.out_byte == 8'h00,
                   "error result carries a byte")
  // once closed, later bytes without a restart keep reporting success
  `JSU_ASSERT_NEXT(a_done_sticky, s1_adv && state_q.phase == PH_DONE && !s1_item_q.first_char,
                   s2_valid_q && s2_result_q.status == ST_OK, "closed string lost its status")
  // the state only moves when a request moves into the result stage
  `JSU_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(state_q), "decoder state moved without request")

endmodule

[design/jsu_decode.sv]
// next-state and result logic for one text byte
module jsu_decode import jsu_pkg::*; (
  input  jsu_state_t  state_i,
  input  jsu_item_t   item_i,
  output jsu_state_t  state_o,
  output jsu_result_t result_o
);

  logic [PhaseW-1:0] ph_cur;
  logic [PhaseW-1:0] ph_nxt;
  logic [AccumW-1:0] acc_cur;
  logic [AccumW-1:0] acc_nxt;
  logic [AccumW-1:0] acc_shift;
  logic [4:0]        digit;
  logic [7:0]        c;
  logic [7:0]        emit;
  logic              valid;
  logic              hex_last;

  always_comb begin
    c         = item_i.text_char;
    ph_cur    = item_i.first_char ? PH_SKIP : state_i.phase;
    acc_cur   = item_i.first_char ? '0 : state_i.accum;
    ph_nxt    = ph_cur;
    acc_nxt   = acc_cur;
    emit      = '0;
    valid     = 1'b0;
    digit     = hex_val(c);
    acc_shift = {acc_cur[AccumW-5:0], digit[3:0]};
    hex_last  = (ph_cur == PH_HEX3);

    unique case (ph_cur)
      PH_SKIP: begin
        if (is_ws(c)) ph_nxt = PH_SKIP;
        else if (c == CH_QUOTE) ph_nxt = PH_STR;
        else ph_nxt = PH_ERR;
      end
      PH_STR: begin
        if (c == CH_QUOTE) ph_nxt = PH_DONE;
        else if (c < CH_SPACE) ph_nxt = PH_ERR;
        else if (c == CH_BSLASH) ph_nxt = PH_ESC;
        else begin
          emit  = c;
          valid = 1'b1;
        end
      end
      PH_ESC: begin
        ph_nxt = PH_STR;
        valid  = 1'b1;
        unique case (c)
          CH_QUOTE:  emit = CH_QUOTE;
          CH_BSLASH: emit = CH_BSLASH;
          CH_SLASH:  emit = CH_SLASH;
          8'h62:     emit = CH_BS;
          8'h66:     emit = CH_FF;
          8'h6e:     emit = CH_LF;
          8'h72:     emit = CH_CR;
          8'h74:     emit = CH_TAB;
          8'h75: begin
            valid   = 1'b0;
            ph_nxt  = PH_HEX0;
            acc_nxt = '0;
          end
          default: begin
            valid  = 1'b0;
            ph_nxt = PH_ERR;
          end
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (digit[4]) ph_nxt = PH_ERR;
        else begin
          acc_nxt = acc_shift;
          if (!hex_last) ph_nxt = ph_cur + 4'd1;
          else if (acc_shift > {8'h00, CH_ASCII_MAX}) ph_nxt = PH_ERR;
          else begin
            emit   = acc_shift[7:0];
            valid  = 1'b1;
            ph_nxt = PH_STR;
          end
        end
      end
      PH_DONE: ph_nxt = PH_DONE;
      default: ph_nxt = PH_ERR;
    endcase

    // text that runs out before the closing quote
    if (item_i.last_char && ph_nxt != PH_DONE && ph_nxt != PH_ERR) ph_nxt = PH_ERR;

    if (ph_nxt == PH_DONE) result_o.status = ST_OK;
    else if (ph_nxt == PH_ERR) result_o.status = ST_ERR;
    else result_o.status = ST_BUSY;
    if (ph_nxt == PH_ERR) valid = 1'b0;

    result_o.byte_valid = valid;
    result_o.out_byte   = valid ? emit : '0;
    state_o.phase       = ph_nxt;
    state_o.accum       = acc_nxt;
  end

endmodule

[bench/json_string_unescape_top_tb.sv]
// self-checking testbench of the json string unescape block: directed and random text streams
`timescale 1ns / 100ps

module json_string_unescape_top_tb;
  import jsu_pkg::*;

  // clock period halves and the run limit, in ns
  localparam int HALF_PERIOD = 4;
  localparam int RUN_LIMIT_NS = 2_000_000;
  // a result leaves the block through its input and result registers; extra cycles waited at the end
  localparam int SETTLE_CYCLES = 8;
  // random text bytes per idling pattern, three patterns in all
  localparam int RANDOM_BYTES_PER_PHASE = 485;

  // escape letters and the one blank the package does not name
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] ESC_B = "b";
  localparam logic [7:0] ESC_F = "f";
  localparam logic [7:0] ESC_N = "n";
  localparam logic [7:0] ESC_R = "r";
  localparam logic [7:0] ESC_T = "t";
  localparam logic [7:0] ESC_U = "u";

  // pieces a random string body is built from; the last four break the string
  typedef enum int {
    TOK_PLAIN,
    TOK_SIMPLE_ESC,
    TOK_UNI_OK,
    TOK_UNI_BIG,
    TOK_BAD_HEX,
    TOK_BAD_ESC,
    TOK_CTRL
  } tok_kind_e;

  typedef logic [7:0] text_q_t[$];

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_char_i = 8'h00;
  logic       first_char_i = 1'b0;
  logic       last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic [1:0] status_o;

  // idling percentages of the text sender and the result receiver
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // decoder state mirrored by the predictor
  logic [PhaseW-1:0] dec_phase = PH_SKIP;
  logic [AccumW-1:0] dec_code = '0;

  // decoded results still owed by the block, oldest first
  jsu_result_t expected_decodes[$];

  int err_count = 0;
  int bytes_sent = 0;
  int values_sent = 0;
  int n_decoded = 0;
  int n_closed = 0;
  int n_failed = 0;

  json_string_unescape_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_char_i (text_char_i),
    .first_char_i(first_char_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b1;
    #HALF_PERIOD;
    clk_i = 1'b0;
    #HALF_PERIOD;
  end

  // hard stop in case a request or a result never shows up
  initial begin
    #RUN_LIMIT_NS;
    $display("json_string_unescape_top_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // character helpers
  // ---------------------------------------------------------------------------

  // json blanks: space, tab, lf, vt, ff, cr
  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  // digit value in the low nibble, bit 4 set for a non-hex byte
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'hff;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") d = c - "A" + 8'd10;
    return (d == 8'hff) ? 5'h10 : d[4:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (upper ? 8'h37 : 8'h57) + {4'h0, v};
  endfunction

  function automatic logic [7:0] blank_char(input int k);
    case (k)
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] escape_letter(input int k);
    case (k)
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return ESC_B;
      4: return ESC_F;
      5: return ESC_N;
      6: return ESC_R;
      default: return ESC_T;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: advances the mirrored decoder by one text byte
  // ---------------------------------------------------------------------------
  function automatic jsu_result_t decode_text_char(input jsu_item_t req);
    jsu_result_t r;
    logic [7:0]  c;
    logic [4:0]  nib;
    c = req.text_char;
    r = '0;
    // a first byte restarts the decoder whatever it was doing
    if (req.first_char) begin
      dec_phase = PH_SKIP;
      dec_code = '0;
    end
    case (dec_phase)
      PH_SKIP: begin
        if (c == CH_QUOTE) dec_phase = PH_STR;
        else if (!is_blank(c)) dec_phase = PH_ERR;
      end
      PH_STR: begin
        if (c == CH_QUOTE) dec_phase = PH_DONE;
        else if (c < CH_SPACE) dec_phase = PH_ERR;
        else if (c == CH_BSLASH) dec_phase = PH_ESC;
        else begin
          // bytes from 0x80 up pass through like any printable byte
          r.out_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      PH_ESC: begin
        dec_phase = PH_STR;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: begin
            r.out_byte = c;
            r.byte_valid = 1'b1;
          end
          ESC_B: begin r.out_byte = CH_BS; r.byte_valid = 1'b1; end
          ESC_F: begin r.out_byte = CH_FF; r.byte_valid = 1'b1; end
          ESC_N: begin r.out_byte = CH_LF; r.byte_valid = 1'b1; end
          ESC_R: begin r.out_byte = CH_CR; r.byte_valid = 1'b1; end
          ESC_T: begin r.out_byte = CH_TAB; r.byte_valid = 1'b1; end
          ESC_U: begin
            dec_phase = PH_HEX0;
            dec_code = '0;
          end
          default: dec_phase = PH_ERR;
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        nib = digit_of(c);
        if (nib[4]) dec_phase = PH_ERR;
        else begin
          dec_code = {dec_code[AccumW-5:0], nib[3:0]};
          if (dec_phase != PH_HEX3) dec_phase = dec_phase + 4'd1;
          else if (dec_code > {8'h00, CH_ASCII_MAX}) dec_phase = PH_ERR;
          else begin
            r.out_byte = dec_code[7:0];
            r.byte_valid = 1'b1;
            dec_phase = PH_STR;
          end
        end
      end
      PH_DONE: ;
      default: dec_phase = PH_ERR;
    endcase
    // text that runs out before the closing quote is an error
    if (req.last_char && dec_phase != PH_DONE && dec_phase != PH_ERR) dec_phase = PH_ERR;
    if (dec_phase == PH_DONE) r.status = ST_OK;
    else if (dec_phase == PH_ERR) begin
      r.status = ST_ERR;
      r.byte_valid = 1'b0;
    end else r.status = ST_BUSY;
    if (!r.byte_valid) r.out_byte = '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // drives one text byte, called and returning at a falling edge; valid stays high on
  // return so back-to-back requests never drop it
  task automatic send_char(input logic [7:0] c, input logic first, input logic last);
    jsu_item_t req;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_char_i <= c;
    first_char_i <= first;
    last_char_i <= last;
    // the sampled stall is the value from before the edge
    do @(posedge clk_i); while (in_stall_o);
    req.text_char = c;
    req.first_char = first;
    req.last_char = last;
    expected_decodes.push_back(decode_text_char(req));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input text_q_t t, input bit mark_last);
    int i;
    for (i = 0; i < t.size(); i++) send_char(t[i], i == 0, mark_last && i == t.size() - 1);
    values_sent++;
  endtask

  // same for readable directed text
  task automatic send_str(input string s, input bit first, input bit mark_last);
    int i;
    for (i = 0; i < s.len(); i++)
      send_char(s[i], first && i == 0, mark_last && i == s.len() - 1);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // random text generation
  // ---------------------------------------------------------------------------
  task automatic add_token(inout text_q_t t, input tok_kind_e kind);
    logic [15:0] code;
    logic [7:0]  c;
    logic [4:0]  nib;
    int          k;
    case (kind)
      TOK_PLAIN: begin
        do c = 8'($urandom_range(8'h20, 8'hff)); while (c == CH_QUOTE || c == CH_BSLASH);
        t.push_back(c);
      end
      TOK_SIMPLE_ESC: begin
        t.push_back(CH_BSLASH);
        t.push_back(escape_letter($urandom_range(7)));
      end
      TOK_UNI_OK, TOK_UNI_BIG: begin
        if (kind == TOK_UNI_OK) code = 16'($urandom_range(0, 16'h007f));
        else code = 16'($urandom_range(16'h0080, 16'hffff));
        t.push_back(CH_BSLASH);
        t.push_back(ESC_U);
        for (k = 3; k >= 0; k--) t.push_back(hex_char(code[4*k +: 4], 1'($urandom_range(1))));
      end
      TOK_BAD_HEX: begin
        // up to three good digits, then one that is not hex
        t.push_back(CH_BSLASH);
        t.push_back(ESC_U);
        repeat ($urandom_range(3))
          t.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        do begin
          c = 8'($urandom_range(255));
          nib = digit_of(c);
        end while (!nib[4]);
        t.push_back(c);
      end
      TOK_BAD_ESC: begin
        // any byte after the backslash, mostly not a legal escape
        t.push_back(CH_BSLASH);
        t.push_back(8'($urandom_range(255)));
      end
      default: t.push_back(8'($urandom_range(8'h1f)));
    endcase
  endtask

  // one value: blanks, quote, body, quote; a broken one carries at most one defect
  task automatic build_value(input bit broken, output text_q_t t, output bit mark_last);
    int n_tok, bad_at, i, mode;
    t = {};
    mark_last = 1'($urandom_range(1));
    mode = $urandom_range(5);
    repeat ($urandom_range(3)) t.push_back(blank_char($urandom_range(5)));
    t.push_back(CH_QUOTE);
    n_tok = $urandom_range(8);
    bad_at = $urandom_range(n_tok);
    for (i = 0; i <= n_tok; i++) begin
      if (broken && mode < 4 && i == bad_at) add_token(t, tok_kind_e'(TOK_UNI_BIG + mode));
      if (i < n_tok) add_token(t, tok_kind_e'($urandom_range(TOK_UNI_OK)));
    end
    t.push_back(CH_QUOTE);
    if (broken && mode == 4) begin
      // text runs out before the closing quote
      repeat ($urandom_range(1, 3)) if (t.size() > 1) t.delete(t.size() - 1);
      mark_last = ($urandom_range(3) != 0);
    end else if (broken && mode == 5) begin
      t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255));
    end else if (!broken && $urandom_range(4) == 0) begin
      // stray bytes after the close must change nothing
      repeat ($urandom_range(1, 2)) t.push_back(8'($urandom_range(255)));
    end
  endtask

  // raw bytes with first and last marks at random, restarts mid-string included
  task automatic send_noise();
    int n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++)
      send_char(8'($urandom_range(255)), $urandom_range(9) == 0, $urandom_range(9) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // blanks before the quote, high and low printable bytes, escape, close on the last
  // byte, then a stray byte after success
  task automatic test_blank_skip_and_close();
    send_char(CH_SPACE, 1'b1, 1'b0);
    send_char(CH_VT, 1'b0, 1'b0);
    send_char(CH_QUOTE, 1'b0, 1'b0);
    send_char(8'hff, 1'b0, 1'b0);
    send_char(CH_SPACE, 1'b0, 1'b0);
    send_str("\\t\"", 1'b0, 1'b1);
    send_char("z", 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // largest allowed u escape, then the smallest one over the limit, then a byte after error
  task automatic test_unicode_escapes();
    send_str("\"\\u007F\\u0080a", 1'b1, 1'b0);
    wait_results_drained();
  endtask

  // every way into the error state but the over-limit u escape
  task automatic test_error_paths();
    // neither blank nor quote before the value
    send_char("x", 1'b1, 1'b0);
    // raw control byte inside the string
    send_char(CH_QUOTE, 1'b1, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    // unknown escape
    send_str("\"\\q", 1'b1, 1'b0);
    // last byte would decode but the string is still open
    send_str("\"a", 1'b1, 1'b1);
    // non-hex digit in a u escape
    send_str("\"\\ug", 1'b1, 1'b0);
    wait_results_drained();
  endtask

  // mostly well-formed values with random content, some broken ones and some noise
  task automatic test_random_values(input int n_bytes, input int snd_pct, input int rcv_pct);
    int      goal, pick;
    text_q_t t;
    bit      mark_last;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 90) begin
        build_value(pick >= 65, t, mark_last);
        send_text(t, mark_last);
      end else send_noise();
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stall, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // each accepted result is matched against the oldest owed one
  always @(posedge clk_i) begin
    jsu_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_decodes.size() == 0) begin
        $error("result with none owed: out_byte %02h byte_valid %b status %0d",
               out_byte_o, byte_valid_o, status_o);
        err_count++;
      end else begin
        want = expected_decodes.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
          err_count++;
        end
        if (byte_valid_o !== want.byte_valid) begin
          $error("byte_valid: expected %b, got %b", want.byte_valid, byte_valid_o);
          err_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (want.byte_valid) n_decoded++;
        if (want.status == ST_OK) n_closed++;
        if (want.status == ST_ERR) n_failed++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    // reset held low, released on a falling edge
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 61;
    test_blank_skip_and_close();
    test_unicode_escapes();
    test_error_paths();

    test_random_values(RANDOM_BYTES_PER_PHASE, 27, 61);
    test_random_values(RANDOM_BYTES_PER_PHASE, 61, 27);
    test_random_values(RANDOM_BYTES_PER_PHASE, 0, 0);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d text bytes over %0d random values plus directed strings",
             bytes_sent, values_sent);
    $display("results: %0d decoded bytes, %0d closed-string and %0d error statuses",
             n_decoded, n_closed, n_failed);
    if (err_count == 0) begin
      $display("json_string_unescape_top_tb: done, clean");
    end else begin
      $display("json_string_unescape_top_tb: done, errors");
    end
    $finish;
  end

endmodule
